// ===== rtl/twdp_pkg.sv =====
// shared types, constants and saturating arithmetic for the ternary dot-product unit
package twdp_pkg;

  localparam int ACC_W     = 40;
  localparam int BIAS_W    = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef logic signed [OUT_W-1:0]  dot_t;

  typedef enum logic [1:0] {
    W_ZERO     = 2'd0,
    W_PLUS     = 2'd1,
    W_MINUS    = 2'd2,
    W_ZERO_ALT = 2'd3
  } wcode_t;

  typedef enum logic {
    CMD_ACCUMULATE = 1'b0,
    CMD_LOAD_BIAS  = 1'b1
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LANES = CFG_IDX_W'(1);

  // add or subtract with clamp at the accumulator limits
  function automatic acc_t acc_addsub(input acc_t a, input acc_t b, input logic sub);
    logic [ACC_W:0] s;
    s = sub ? ({a[ACC_W-1], a} - {b[ACC_W-1], b}) : ({a[ACC_W-1], a} + {b[ACC_W-1], b});
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? acc_t'(ACC_MIN) : acc_t'(ACC_MAX);
    end
    return acc_t'(s[ACC_W-1:0]);
  endfunction

  // accumulator plus bias, clamped to the result width
  function automatic dot_t dot_sat(input acc_t a, input bias_t b);
    logic [ACC_W:0] s;
    logic [ACC_W-OUT_W+1:0] top;
    s   = {a[ACC_W-1], a} + {{(ACC_W+1-BIAS_W){b[BIAS_W-1]}}, b};
    top = s[ACC_W:OUT_W-1];
    if ((&top) || !(|top)) begin
      return dot_t'(s[OUT_W-1:0]);
    end
    return s[ACC_W] ? dot_t'(OUT_MIN) : dot_t'(OUT_MAX);
  endfunction

endpackage

// ===== rtl/twdp_in_if.sv =====
// input channel: accumulate and bias-load beats
interface twdp_in_if #(
  parameter int LANES     = 12,
  parameter int ACT_WIDTH = 16
);
  import twdp_pkg::*;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [ACT_WIDTH-1:0] activation;
  logic [2*LANES-1:0]       weight_codes;
  logic [LANE_W-1:0]        bias_lane;
  logic signed [BIAS_W-1:0] bias_value;
  logic                     last_element;

  modport source (output valid, command, activation, weight_codes, bias_lane, bias_value,
                  last_element, input ready);
  modport sink   (input valid, command, activation, weight_codes, bias_lane, bias_value,
                  last_element, output ready);
endinterface

// ===== rtl/twdp_out_if.sv =====
// result channel: one beat per active lane
interface twdp_out_if #(
  parameter int LANES = 12
);
  import twdp_pkg::*;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic                    valid;
  logic                    ready;
  logic [LANE_W-1:0]       lane_index;
  logic signed [OUT_W-1:0] dot_value;
  logic                    last_result;

  modport source (output valid, lane_index, dot_value, last_result, input ready);
  modport sink   (input valid, lane_index, dot_value, last_result, output ready);
endinterface

// ===== rtl/ternary_weight_dot_product_lanes_unit.sv =====
// top level of the ternary-weight dot-product unit with parallel output lanes
//
// usage
//   in_ch carries accumulate beats (one activation, a 2-bit weight code per lane) and
//   bias-load beats; out_ch returns one beat per active lane after an accumulate beat
//   marked last_element, lanes in ascending order, last_result on the highest one.
//   cfg_we/cfg_index/cfg_data set bias_enable and active_lanes; write only when idle.
// timing
//   every beat is registered on entry and applied from there, so one beat per cycle is
//   taken while no last beat waits. results pass through the snapshot bank into the
//   result register and follow one per cycle while out_ch.ready stays high.
//   a finished dot product is copied into a snapshot bank and the lanes are cleared,
//   so accumulation of the next vector overlaps the draining of results. a second
//   last beat waits in the entry register until the snapshot bank has drained.
// reset
//   synchronous, active low: accumulators and biases zero, bias_enable 0, all lanes
//   active, no beats pending.
// stall
//   a low out_ch.ready holds the result register; draining pauses and, once a further
//   last beat waits, in_ch.ready drops.
module ternary_weight_dot_product_lanes_unit #(
  parameter int LANES     = 12,
  parameter int ACT_WIDTH = 16,
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1,
  localparam int CNT_W    = $clog2(LANES + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [twdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CNT_W-1:0]                   cfg_data,
  twdp_in_if.sink                            in_ch,
  twdp_out_if.source                         out_ch
);
  import twdp_pkg::*;

  // configuration
  logic             bias_en_r;
  logic [CNT_W-1:0] act_lanes_r;

  // entry register
  logic                        in_vld_r;
  logic                        in_cmd_r;
  logic signed [ACT_WIDTH-1:0] in_act_r;
  logic [2*LANES-1:0]          in_codes_r;
  logic [LANE_W-1:0]           in_lane_r;
  bias_t                       in_bias_r;
  logic                        in_last_r;

  // lane state
  acc_t  acc_r   [LANES];
  acc_t  acc_upd [LANES];
  acc_t  acc_nxt [LANES];
  bias_t bias_r  [LANES];

  // snapshot bank
  logic              snap_vld_r;
  acc_t              snap_acc_r  [LANES];
  bias_t             snap_bias_r [LANES];
  logic [LANE_W-1:0] snap_last_r;
  logic [LANE_W-1:0] emit_idx_r;

  // result register
  logic              out_vld_r;
  logic [LANE_W-1:0] out_lane_r;
  dot_t              out_dot_r;
  logic              out_last_r;

  logic              in_take;
  logic              in_go;
  logic              is_acc;
  logic              snap_take;
  logic              out_load;
  logic              emit_done;
  logic              bias_wr;
  acc_t              act_ext;
  logic [CNT_W-1:0]  n_clamped;

  // handshake and control
  assign out_load  = snap_vld_r && (!out_vld_r || out_ch.ready);
  assign emit_done = out_load && (emit_idx_r == snap_last_r);
  assign is_acc    = (cmd_t'(in_cmd_r) == CMD_ACCUMULATE);
  // a last beat may go only when the snapshot bank is free or frees this cycle
  assign in_go     = in_vld_r && (!(is_acc && in_last_r) || !snap_vld_r || emit_done);
  assign snap_take = in_go && is_acc && in_last_r;
  assign in_ch.ready = !in_vld_r || in_go;
  assign in_take   = in_ch.valid && in_ch.ready;
  assign bias_wr   = in_go && !is_acc && (32'(in_lane_r) < 32'(LANES));

  assign act_ext = {{(ACC_W-ACT_WIDTH){in_act_r[ACT_WIDTH-1]}}, in_act_r};

  // lane count clamped to 1..LANES
  always_comb begin
    if (act_lanes_r == '0) begin
      n_clamped = CNT_W'(1);
    end else if (32'(act_lanes_r) > 32'(LANES)) begin
      n_clamped = CNT_W'(LANES);
    end else begin
      n_clamped = act_lanes_r;
    end
  end

  // per-lane add, subtract or hold; cleared on a last accumulate beat
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      unique case (wcode_t'(in_codes_r[2*i +: 2]))
        W_PLUS:             acc_upd[i] = acc_addsub(acc_r[i], act_ext, 1'b0);
        W_MINUS:            acc_upd[i] = acc_addsub(acc_r[i], act_ext, 1'b1);
        W_ZERO, W_ZERO_ALT: acc_upd[i] = acc_r[i];
        default:            acc_upd[i] = acc_r[i];
      endcase
      if (in_go && is_acc) begin
        acc_nxt[i] = in_last_r ? acc_t'(0) : acc_upd[i];
      end else begin
        acc_nxt[i] = acc_r[i];
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_en_r   <= 1'b0;
      act_lanes_r <= CNT_W'(LANES);
    end else if (cfg_we) begin
      if (cfg_index == CFG_BIAS_ENABLE) begin
        bias_en_r <= cfg_data[0];
      end else if (cfg_index == CFG_ACTIVE_LANES) begin
        act_lanes_r <= cfg_data;
      end
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (in_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r   <= in_ch.command;
      in_act_r   <= in_ch.activation;
      in_codes_r <= in_ch.weight_codes;
      in_lane_r  <= in_ch.bias_lane;
      in_bias_r  <= in_ch.bias_value;
      in_last_r  <= in_ch.last_element;
    end
  end

  // lane accumulators and biases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= acc_nxt[i];
        if (bias_wr && (32'(in_lane_r) == i)) begin
          bias_r[i] <= in_bias_r;
        end
      end
    end
  end

  // snapshot bank control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_vld_r <= 1'b0;
      emit_idx_r <= '0;
    end else if (snap_take) begin
      snap_vld_r <= 1'b1;
      emit_idx_r <= '0;
    end else if (out_load) begin
      emit_idx_r <= emit_idx_r + LANE_W'(1);
      if (emit_done) begin
        snap_vld_r <= 1'b0;
      end
    end
  end

  // snapshot payload: final sums and the biases in force at the last beat, zero when bias is disabled
  always_ff @(posedge clk) begin
    if (snap_take) begin
      for (int i = 0; i < LANES; i++) begin
        snap_acc_r[i]  <= acc_upd[i];
        snap_bias_r[i] <= bias_en_r ? bias_r[i] : bias_t'(0);
      end
      snap_last_r <= LANE_W'(n_clamped - CNT_W'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lane_r <= emit_idx_r;
      out_dot_r  <= dot_sat(snap_acc_r[emit_idx_r], snap_bias_r[emit_idx_r]);
      out_last_r <= (emit_idx_r == snap_last_r);
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.lane_index  = out_lane_r;
  assign out_ch.dot_value   = out_dot_r;
  assign out_ch.last_result = out_last_r;

  // checks
  a_snap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    snap_take |-> (!snap_vld_r || emit_done))
    else $error("snapshot bank overwritten while results pending");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    snap_vld_r |-> (emit_idx_r <= snap_last_r))
    else $error("emit index past the last active lane");

  a_last_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !in_go) |=> (in_vld_r && $stable(in_last_r) && $stable(in_cmd_r)))
    else $error("waiting entry beat lost");

  a_bank_freed: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_done && !snap_take) |=> !snap_vld_r)
    else $error("snapshot bank not released after its last result");

endmodule
